// ===== design/depression_storage_split_assert.svh =====
// Assertion macros for the depression storage split block
`ifndef DEPRESSION_STORAGE_SPLIT_ASSERT_SVH
`define DEPRESSION_STORAGE_SPLIT_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked out of reset
`define DSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("depression_storage_split: assertion failed");
// implication form: condition, then what must hold
`define DSS_ASSERT_IMP(lbl, ante, cons) \
    `DSS_ASSERT(lbl, (ante) |-> (cons))
`else
`define DSS_ASSERT(lbl, prop)
`define DSS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/dss_pkg.sv =====
// Package: widths, constants, stage map and pipeline types of the storage split
package dss_pkg;

    // field widths
    localparam int DEPTH_BITS = 24;
    localparam int TAG_W      = 12;
    localparam int AREA_W     = 20;
    localparam int VOL_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int VPROD_W    = DEPTH_BITS + AREA_W;

    // quotient bits of both dividers; exp needs x < 17 * 2^16 < 2^21
    localparam int DIV_STEPS  = (DEPTH_BITS > 21) ? DEPTH_BITS : 21;
    localparam int XREM_W     = DEPTH_BITS + DIV_STEPS;
    localparam int RREM_W     = (VOL_W > AREA_W + DIV_STEPS) ? VOL_W : AREA_W + DIV_STEPS;

    // exp constants
    localparam int              EXP_SCALE   = 122880;     // 1.875 in Q16
    localparam int              EXP_NMAX    = 17;
    localparam int              N_W         = 5;
    localparam int              HORNER_K    = 12;
    localparam int              POW_STEPS   = 16;
    localparam logic [32:0]     Q32_ONE     = 33'h1_0000_0000;
    localparam logic [30:0]     EXP_M1_Q32  = 31'd1580030168;
    localparam logic [16:0]     Q16_ONE     = 17'h1_0000;
    localparam logic [VOL_W-1:0] VOL_MAX    = '1;

    // stage map
    localparam int ST_DIV0  = 2;
    localparam int ST_POST  = ST_DIV0 + DIV_STEPS;
    localparam int ST_H0    = ST_POST + 1;
    localparam int ST_RET   = ST_H0;
    localparam int ST_USED  = ST_H0 + 1;
    localparam int ST_P0    = ST_H0 + 3 * HORNER_K;
    localparam int ST_E     = ST_P0 + POW_STEPS;
    localparam int ST_SPLIT = ST_E + 1;
    localparam int ST_VOL   = ST_SPLIT + 1;
    localparam int ST_OUT   = ST_VOL + 1;
    localparam int N_STAGE  = ST_OUT + 1;

    // one cell in flight
    typedef struct packed {
        logic [TAG_W-1:0]      row;
        logic [TAG_W-1:0]      col;
        logic                  flood;
        logic                  wh_zero;
        logic [DEPTH_BITS-1:0] wh;
        logic [DEPTH_BITS-1:0] maxs;
        logic [DEPTH_BITS-1:0] rough;
        logic [AREA_W-1:0]     area;
        logic                  act;
        logic [VOL_W-1:0]      used;
        logic [XREM_W-1:0]     xr;
        logic [DIV_STEPS-1:0]  xq;
        logic                  xsat;
        logic [RREM_W-1:0]     rr;
        logic [DIV_STEPS-1:0]  rq;
        logic                  rsat;
        logic [DEPTH_BITS-1:0] dh;
        logic [VPROD_W-1:0]    dha;
        logic [FRAC_W-1:0]     f;
        logic [N_W-1:0]        n;
        logic                  ezero;
        logic [32:0]           t;
        logic [31:0]           p;
        logic [31:0]           qe;
        logic [DEPTH_BITS-1:0] mds;
        logic [DEPTH_BITS-1:0] runoff;
        logic [DEPTH_BITS-1:0] stored;
        logic [DEPTH_BITS-1:0] nd;
        logic [VPROD_W-1:0]    vs;
        logic [VPROD_W-1:0]    vn;
        logic [VOL_W-1:0]      vol_s;
        logic [VOL_W-1:0]      vol_n;
    } t_item;

endpackage

// ===== design/depression_storage_split.sv =====
// Top level: pipelined depression storage / runoff split, one cell per clock
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  cell in   | start / busy       | i_cell_row .. i_retention_used
//  result    | o_strobe (1 cycle) | o_out_row .. o_retention_used_out
//  config    | i_cfg_we           | i_cfg_wdata (retention enable)
//
// After acceptance, a cell passes through the N_STAGE pipeline stages: capture
// and overflow check (2), two 24-step restoring dividers side by side, the n / f
// split (1), twelve 3-stage Horner steps of the exp series, sixteen conditional
// exp(-1) multiply stages and four output stages. One cell may enter every clock;
// busy stays low. Reset clears the valid bits and the enable; cells in flight are
// dropped. No stall on the result side.
`include "depression_storage_split_assert.svh"

module depression_storage_split (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [dss_pkg::TAG_W-1:0]      i_cell_row,
    input  logic [dss_pkg::TAG_W-1:0]      i_cell_col,
    input  logic                           i_flood_cell,
    input  logic [dss_pkg::DEPTH_BITS-1:0] i_water_depth,
    input  logic [dss_pkg::DEPTH_BITS-1:0] i_max_storage,
    input  logic [dss_pkg::DEPTH_BITS-1:0] i_roughness_length,
    input  logic                           i_has_channel,
    input  logic [dss_pkg::AREA_W-1:0]     i_cell_area,
    input  logic [dss_pkg::VOL_W-1:0]      i_retention_capacity,
    input  logic [dss_pkg::VOL_W-1:0]      i_retention_used,
    output logic                           o_strobe,
    output logic [dss_pkg::TAG_W-1:0]      o_out_row,
    output logic [dss_pkg::TAG_W-1:0]      o_out_col,
    output logic                           o_out_flood_cell,
    output logic [dss_pkg::DEPTH_BITS-1:0] o_runoff_depth,
    output logic [dss_pkg::DEPTH_BITS-1:0] o_stored_depth,
    output logic [dss_pkg::DEPTH_BITS-1:0] o_new_depth,
    output logic [dss_pkg::VOL_W-1:0]      o_stored_volume,
    output logic [dss_pkg::VOL_W-1:0]      o_water_volume,
    output logic [dss_pkg::VOL_W-1:0]      o_retention_used_out
);

    localparam int DB = dss_pkg::DEPTH_BITS;
    localparam int NS = dss_pkg::N_STAGE;

    logic                 r_ret_en;
    logic                 n_ret_en;
    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        n_vld;
    dss_pkg::t_item       r_pipe [NS];
    dss_pkg::t_item       n_st   [NS];
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // retention enable register
    assign n_ret_en = i_cfg_we ? i_cfg_wdata : r_ret_en;

    // valid bits move one stage a clock
    assign n_vld = {r_vld[NS-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ret_en <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_ret_en <= n_ret_en;
            r_vld    <= n_vld;
        end
    end

    // capture: exp numerator and free retention volume
    always_comb begin
        n_st[0]         = '0;
        n_st[0].row     = i_cell_row;
        n_st[0].col     = i_cell_col;
        n_st[0].flood   = i_flood_cell;
        n_st[0].wh      = i_water_depth;
        n_st[0].wh_zero = (i_water_depth == '0);
        n_st[0].maxs    = i_max_storage;
        n_st[0].rough   = i_roughness_length;
        n_st[0].area    = i_cell_area;
        n_st[0].used    = i_retention_used;
        n_st[0].act     = r_ret_en && !i_has_channel
                          && (i_retention_capacity > i_retention_used);
        n_st[0].xr      = dss_pkg::XREM_W'(i_water_depth)
                          * dss_pkg::XREM_W'(dss_pkg::EXP_SCALE);
        n_st[0].rr      = n_st[0].act
                          ? dss_pkg::RREM_W'(i_retention_capacity - i_retention_used)
                          : '0;
    end

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= n_st[0];
    end

    // stages 1 .. NS-1
    for (genvar s = 1; s < NS; s++) begin : g_stage
        localparam bit IN_DIV = (s >= dss_pkg::ST_DIV0) && (s < dss_pkg::ST_POST);
        localparam int DBIT   = IN_DIV ? (dss_pkg::DIV_STEPS - 1 - (s - dss_pkg::ST_DIV0)) : 0;
        localparam bit IN_H   = (s >= dss_pkg::ST_H0) && (s < dss_pkg::ST_P0);
        localparam int HJ     = IN_H ? (s - dss_pkg::ST_H0) / 3 : 0;
        localparam int HPH    = IN_H ? (s - dss_pkg::ST_H0) % 3 : 0;
        localparam int K      = dss_pkg::HORNER_K - HJ;
        localparam logic [32:0] RECIP = 33'(dss_pkg::Q32_ONE / K);
        localparam bit IN_P   = (s >= dss_pkg::ST_P0) && (s < dss_pkg::ST_E);
        localparam int PI     = IN_P ? s - dss_pkg::ST_P0 : 0;

        logic [48:0]                    prod_h;
        logic [64:0]                    prod_m;
        logic [35:0]                    prod_k;
        logic [31:0]                    rem;
        logic [31:0]                    qq;
        logic [64:0]                    prod_p;
        logic [33:0]                    sum_e;
        logic [16:0]                    e;
        logic [DB+16:0]                 prod_e;
        logic [dss_pkg::XREM_W-1:0]     xcand;
        logic [dss_pkg::RREM_W-1:0]     rcand;

        always_comb begin
            n_st[s] = r_pipe[s-1];
            prod_h  = '0;
            prod_m  = '0;
            prod_k  = '0;
            rem     = '0;
            qq      = '0;
            prod_p  = '0;
            sum_e   = '0;
            e       = '0;
            prod_e  = '0;
            xcand   = '0;
            rcand   = '0;

            // overflow checks: quotient would not fit DIV_STEPS bits
            if (s == 1) begin
                n_st[s].xsat = r_pipe[s-1].xr >=
                    (dss_pkg::XREM_W'(r_pipe[s-1].rough) << dss_pkg::DIV_STEPS);
                n_st[s].rsat = r_pipe[s-1].rr >=
                    (dss_pkg::RREM_W'(r_pipe[s-1].area) << dss_pkg::DIV_STEPS);
                n_st[s].xq   = '0;
                n_st[s].rq   = '0;
            end

            // restoring division, one quotient bit of each divider
            if (IN_DIV) begin
                xcand = dss_pkg::XREM_W'(r_pipe[s-1].rough) << DBIT;
                rcand = dss_pkg::RREM_W'(r_pipe[s-1].area) << DBIT;
                if (r_pipe[s-1].xr >= xcand) begin
                    n_st[s].xr       = r_pipe[s-1].xr - xcand;
                    n_st[s].xq[DBIT] = 1'b1;
                end
                if (r_pipe[s-1].rr >= rcand) begin
                    n_st[s].rr       = r_pipe[s-1].rr - rcand;
                    n_st[s].rq[DBIT] = 1'b1;
                end
            end

            // split x into n and f; depth taken by retention
            if (s == dss_pkg::ST_POST) begin
                n_st[s].f     = r_pipe[s-1].xq[dss_pkg::FRAC_W-1:0];
                n_st[s].ezero = r_pipe[s-1].xsat
                    || (r_pipe[s-1].xq[dss_pkg::DIV_STEPS-1:dss_pkg::FRAC_W]
                        >= (dss_pkg::DIV_STEPS - dss_pkg::FRAC_W)'(dss_pkg::EXP_NMAX));
                n_st[s].n     = n_st[s].ezero ? '0
                    : dss_pkg::N_W'(r_pipe[s-1].xq[dss_pkg::DIV_STEPS-1:dss_pkg::FRAC_W]);
                n_st[s].t     = dss_pkg::Q32_ONE;
                if (!r_pipe[s-1].act) begin
                    n_st[s].dh = '0;
                end else if (r_pipe[s-1].rsat
                             || r_pipe[s-1].rq >= dss_pkg::DIV_STEPS'(r_pipe[s-1].wh)) begin
                    n_st[s].dh = r_pipe[s-1].wh;
                end else begin
                    n_st[s].dh = DB'(r_pipe[s-1].rq);
                end
            end

            // remove taken depth; volume it fills
            if (s == dss_pkg::ST_RET) begin
                n_st[s].wh  = r_pipe[s-1].wh - r_pipe[s-1].dh;
                n_st[s].dha = dss_pkg::VPROD_W'(r_pipe[s-1].dh)
                              * dss_pkg::VPROD_W'(r_pipe[s-1].area);
            end
            if (s == dss_pkg::ST_USED) begin
                n_st[s].used = r_pipe[s-1].used + dss_pkg::VOL_W'(r_pipe[s-1].dha);
            end

            // Horner step: t = 1 - floor(floor(f*t)/k), three stages
            if (IN_H && HPH == 0) begin
                prod_h    = 49'(r_pipe[s-1].t) * 49'(r_pipe[s-1].f);
                n_st[s].p = prod_h[47:16];
            end
            if (IN_H && HPH == 1) begin
                prod_m     = 65'(r_pipe[s-1].p) * 65'(RECIP);
                n_st[s].qe = prod_m[63:32];
            end
            if (IN_H && HPH == 2) begin
                prod_k    = 36'(r_pipe[s-1].qe) * 36'(K);
                rem       = r_pipe[s-1].p - prod_k[31:0];
                qq        = (rem >= 32'(K)) ? r_pipe[s-1].qe + 32'd1 : r_pipe[s-1].qe;
                n_st[s].t = dss_pkg::Q32_ONE - 33'(qq);
            end

            // integer part: multiply by exp(-1) once per stage below n
            if (IN_P && (r_pipe[s-1].n > dss_pkg::N_W'(PI))) begin
                prod_p    = 65'(r_pipe[s-1].t) * 65'(dss_pkg::EXP_M1_Q32)
                            + (65'd1 << 31);
                n_st[s].t = prod_p[64:32];
            end

            // round to Q16 and scale the storage limit
            if (s == dss_pkg::ST_E) begin
                sum_e = 34'(r_pipe[s-1].t) + 34'h8000;
                if (r_pipe[s-1].wh_zero) begin
                    e = dss_pkg::Q16_ONE;
                end else if (r_pipe[s-1].ezero) begin
                    e = '0;
                end else begin
                    e = sum_e[32:16];
                end
                prod_e      = (DB+17)'(r_pipe[s-1].maxs) * (DB+17)'(dss_pkg::Q16_ONE - e);
                n_st[s].mds = prod_e[DB+15:16];
            end

            // runoff over storage
            if (s == dss_pkg::ST_SPLIT) begin
                if (r_pipe[s-1].wh > r_pipe[s-1].mds) begin
                    n_st[s].runoff = r_pipe[s-1].wh - r_pipe[s-1].mds;
                    n_st[s].stored = r_pipe[s-1].mds;
                end else begin
                    n_st[s].runoff = '0;
                    n_st[s].stored = r_pipe[s-1].wh;
                end
                n_st[s].nd = n_st[s].runoff + n_st[s].stored;
            end

            // volumes
            if (s == dss_pkg::ST_VOL) begin
                n_st[s].vs = dss_pkg::VPROD_W'(r_pipe[s-1].stored)
                             * dss_pkg::VPROD_W'(r_pipe[s-1].area);
                n_st[s].vn = dss_pkg::VPROD_W'(r_pipe[s-1].nd)
                             * dss_pkg::VPROD_W'(r_pipe[s-1].area);
            end

            // saturate volumes to 48 bits
            if (s == dss_pkg::ST_OUT) begin
                n_st[s].vol_s = (64'(r_pipe[s-1].vs) > 64'(dss_pkg::VOL_MAX))
                                ? dss_pkg::VOL_MAX : dss_pkg::VOL_W'(r_pipe[s-1].vs);
                n_st[s].vol_n = (64'(r_pipe[s-1].vn) > 64'(dss_pkg::VOL_MAX))
                                ? dss_pkg::VOL_MAX : dss_pkg::VOL_W'(r_pipe[s-1].vn);
            end
        end

        always_ff @(posedge i_clk) begin
            r_pipe[s] <= n_st[s];
        end
    end

    // result transaction
    assign o_strobe             = r_vld[NS-1];
    assign o_out_row            = r_pipe[NS-1].row;
    assign o_out_col            = r_pipe[NS-1].col;
    assign o_out_flood_cell     = r_pipe[NS-1].flood;
    assign o_runoff_depth       = r_pipe[NS-1].runoff;
    assign o_stored_depth       = r_pipe[NS-1].stored;
    assign o_new_depth          = r_pipe[NS-1].nd;
    assign o_stored_volume      = r_pipe[NS-1].vol_s;
    assign o_water_volume       = r_pipe[NS-1].vol_n;
    assign o_retention_used_out = r_pipe[NS-1].used;

    // checks
    `DSS_ASSERT(a_latency, accept |-> ##NS o_strobe)
    `DSS_ASSERT_IMP(a_no_spurious, o_strobe, $past(accept, NS))
    `DSS_ASSERT_IMP(a_store_limit, r_vld[dss_pkg::ST_SPLIT],
        r_pipe[dss_pkg::ST_SPLIT].stored <= r_pipe[dss_pkg::ST_SPLIT].maxs)
    `DSS_ASSERT_IMP(a_depth_sum, o_strobe, o_new_depth == o_runoff_depth + o_stored_depth)
    `DSS_ASSERT_IMP(a_vol_order, o_strobe, o_stored_volume <= o_water_volume)

endmodule
